FILE: hdl/pds_pkg.sv
// Shared types and constants for the PLL divider search block.
// No dependencies; imported by every module of the block.
package pds_pkg;

    localparam int REF_W      = 20;
    localparam int PIX_W      = 20;
    localparam int N_W        = 8;
    localparam int OD_W       = 3;
    localparam int M_W        = 8;
    localparam int WORD_W     = 32;
    localparam int FRAC_OUT_W = 18;

    localparam int FRAC_BITS_DEF = 18;

    // pix * N << OD at its widest.
    localparam int PROD_W = PIX_W + N_W + (2 ** OD_W) - 1;

    localparam logic [N_W-1:0]  N_START  = N_W'(4);
    localparam logic [N_W-1:0]  N_MIN    = N_W'(1);
    localparam logic [N_W-1:0]  N_MAX    = N_W'(255);
    localparam logic [OD_W-1:0] OD_START = OD_W'(2);
    localparam logic [OD_W-1:0] OD_MIN   = OD_W'(0);
    localparam logic [OD_W-1:0] OD_MAX   = OD_W'(7);
    localparam logic [M_W-1:0]  M_MAX    = M_W'(255);

    localparam int VCO_IN_LOW   = 5000;
    localparam int VCO_IN_HIGH  = 50000;
    localparam int VCO_OUT_LOW  = 200000;
    localparam int VCO_OUT_HIGH = 700000;

    localparam int WORD_FRAC_POS = 14;
    localparam int WORD_OD_POS   = 12;
    localparam int WORD_N_POS    = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_N_LOW,
        ST_N_HIGH,
        ST_OD_LOW,
        ST_OD_HIGH,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } pds_state_t;

    typedef struct packed {
        logic load;
        logic n_low;
        logic n_high;
        logic od_low;
        logic od_high;
        logic mul;
        logic div_step;
        logic finish;
    } pds_cmd_t;

    typedef struct packed {
        logic zero_in;
        logic n_lo_fire;
        logic n_at_min;
        logic n_hi_fire;
        logic n_at_max;
        logic od_lo_fire;
        logic od_at_max;
        logic od_hi_fire;
        logic od_at_min;
        logic moved;
        logic div_last;
        logic out_busy;
    } pds_status_t;

endpackage

FILE: hdl/pds_ctrl.sv
// Sequencer for the PLL divider search: divider searches, multiply, division.
// Depends on pds_pkg for the state, command and status types.
module pds_ctrl
    import pds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  pds_status_t status,
    output pds_cmd_t    cmd
);

    pds_state_t state_reg;
    pds_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_N_LOW;
                end
            end
            ST_N_LOW:
            begin
                if (status.zero_in)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.n_lo_fire && status.n_at_min)
                begin
                    state_next = ST_OD_LOW;
                end
                else
                begin
                    state_next = ST_N_HIGH;
                end
            end
            ST_N_HIGH:
            begin
                if (status.n_hi_fire && status.n_at_max)
                begin
                    state_next = ST_OD_LOW;
                end
                else if (status.n_hi_fire || status.moved)
                begin
                    state_next = ST_N_LOW;
                end
                else
                begin
                    state_next = ST_OD_LOW;
                end
            end
            ST_OD_LOW:
            begin
                if (status.od_lo_fire && status.od_at_max)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_OD_HIGH;
                end
            end
            ST_OD_HIGH:
            begin
                if (status.od_hi_fire && status.od_at_min)
                begin
                    state_next = ST_MUL;
                end
                else if (status.od_hi_fire || status.moved)
                begin
                    state_next = ST_OD_LOW;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_N_LOW:   cmd.n_low    = !status.zero_in;
            ST_N_HIGH:  cmd.n_high   = 1'b1;
            ST_OD_LOW:  cmd.od_low   = 1'b1;
            ST_OD_HIGH: cmd.od_high  = 1'b1;
            ST_MUL:     cmd.mul      = 1'b1;
            ST_DIV:     cmd.div_step = 1'b1;
            ST_FINISH:  cmd.finish   = !status.out_busy;
            default:    cmd          = '0;
        endcase
    end

endmodule

FILE: hdl/pds_datapath.sv
// Datapath of the PLL divider search: divider registers, range compares,
// product, restoring divider and the result register. Depends on pds_pkg.
module pds_datapath
    import pds_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pds_cmd_t              cmd,
    output pds_status_t           status,
    input  logic [REF_W-1:0]      ref_clock_khz,
    input  logic [PIX_W-1:0]      pixel_clock_khz,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [WORD_W-1:0]     pll_word,
    output logic [M_W-1:0]        mult_int,
    output logic [N_W-1:0]        prediv,
    output logic [OD_W-1:0]       postdiv_log,
    output logic [FRAC_OUT_W-1:0] mult_frac,
    output logic                  saturated,
    output logic                  bad_input
);

    localparam int DIVD_W    = PROD_W + FRAC_BITS;
    localparam int Q_W       = FRAC_BITS + M_W;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int LIM_IN_W  = N_W + 16;
    localparam int SH_W      = PIX_W + (2 ** OD_W) - 1;

    logic [REF_W-1:0]  ref_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [N_W-1:0]    n_reg;
    logic [OD_W-1:0]   od_reg;
    logic              sat_reg;
    logic              moved_reg;
    logic              zero_reg;
    logic [DIVD_W-1:0] divd_reg;
    logic [REF_W-1:0]  rem_reg;
    logic [Q_W-1:0]    q_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic [WORD_W-1:0]     word_reg;
    logic [M_W-1:0]        m_reg;
    logic [N_W-1:0]        n_out_reg;
    logic [OD_W-1:0]       od_out_reg;
    logic [FRAC_OUT_W-1:0] frac_reg;
    logic                  sat_out_reg;
    logic                  bad_reg;

    logic [LIM_IN_W-1:0]    lim_lo;
    logic [LIM_IN_W-1:0]    lim_hi;
    logic [SH_W-1:0]        pix_sh;
    logic                   n_lo_fire;
    logic                   n_hi_fire;
    logic                   od_lo_fire;
    logic                   od_hi_fire;
    logic [PIX_W+N_W-1:0]   pix_n;
    logic [PROD_W-1:0]      prod;
    logic [REF_W:0]         rem_shift;
    logic                   rem_ge;
    logic [REF_W:0]         rem_diff;
    logic [M_W-1:0]         m_val;
    logic                   m_ovf;
    logic [FRAC_BITS-1:0]   frac_full;
    logic [FRAC_OUT_W-1:0]  frac18;
    logic [WORD_W-1:0]      word_val;

    // ref/N < low is ref < N*low; ref/N > high is ref >= N*(high+1).
    assign lim_lo    = LIM_IN_W'(n_reg) * LIM_IN_W'(VCO_IN_LOW);
    assign lim_hi    = LIM_IN_W'(n_reg) * LIM_IN_W'(VCO_IN_HIGH + 1);
    assign n_lo_fire = LIM_IN_W'(ref_reg) < lim_lo;
    assign n_hi_fire = LIM_IN_W'(ref_reg) >= lim_hi;

    assign pix_sh     = SH_W'(pix_reg) << od_reg;
    assign od_lo_fire = pix_sh < SH_W'(VCO_OUT_LOW);
    assign od_hi_fire = pix_sh > SH_W'(VCO_OUT_HIGH);

    assign pix_n = (PIX_W+N_W)'(pix_reg) * (PIX_W+N_W)'(n_reg);
    assign prod  = PROD_W'(pix_n) << od_reg;

    assign rem_shift = {rem_reg, divd_reg[DIVD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, ref_reg};
    assign rem_diff  = rem_shift - {1'b0, ref_reg};

    assign m_ovf     = ovf_reg || (q_reg[Q_W-1:FRAC_BITS] > M_MAX);
    assign m_val     = m_ovf ? M_MAX : q_reg[Q_W-1:FRAC_BITS];
    assign frac_full = q_reg[FRAC_BITS-1:0];
    assign frac18    = FRAC_OUT_W'(frac_full);
    // The fields overlap in the packed word, so they are added, not merged.
    assign word_val  = (WORD_W'(frac18) << WORD_FRAC_POS)
                     + (WORD_W'(od_reg) << WORD_OD_POS)
                     + (WORD_W'(n_reg) << WORD_N_POS)
                     + WORD_W'(m_val);

    always_comb
    begin
        status            = '0;
        status.zero_in    = zero_reg;
        status.n_lo_fire  = n_lo_fire;
        status.n_at_min   = n_reg <= N_MIN;
        status.n_hi_fire  = n_hi_fire;
        status.n_at_max   = n_reg >= N_MAX;
        status.od_lo_fire = od_lo_fire;
        status.od_at_max  = od_reg >= OD_MAX;
        status.od_hi_fire = od_hi_fire;
        status.od_at_min  = od_reg == OD_MIN;
        status.moved      = moved_reg;
        status.div_last   = cnt_reg == CNT_W'(DIV_STEPS - 1);
        status.out_busy   = rsp_valid_reg && !rsp_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ref_reg   <= ref_clock_khz;
            pix_reg   <= pixel_clock_khz;
            n_reg     <= N_START;
            od_reg    <= OD_START;
            sat_reg   <= 1'b0;
            moved_reg <= 1'b0;
            zero_reg  <= (ref_clock_khz == '0) || (pixel_clock_khz == '0);
        end
        if (cmd.n_low)
        begin
            moved_reg <= n_lo_fire && (n_reg > N_MIN);
            if (n_lo_fire)
            begin
                if (n_reg <= N_MIN)
                begin
                    sat_reg <= 1'b1;
                end
                else
                begin
                    n_reg <= n_reg - N_W'(1);
                end
            end
        end
        if (cmd.n_high && n_hi_fire)
        begin
            if (n_reg >= N_MAX)
            begin
                sat_reg <= 1'b1;
            end
            else
            begin
                n_reg <= n_reg + N_W'(1);
            end
        end
        if (cmd.od_low)
        begin
            moved_reg <= od_lo_fire && (od_reg < OD_MAX);
            if (od_lo_fire)
            begin
                if (od_reg >= OD_MAX)
                begin
                    sat_reg <= 1'b1;
                end
                else
                begin
                    od_reg <= od_reg + OD_W'(1);
                end
            end
        end
        if (cmd.od_high && od_hi_fire)
        begin
            if (od_reg == OD_MIN)
            begin
                sat_reg <= 1'b1;
            end
            else
            begin
                od_reg <= od_reg - OD_W'(1);
            end
        end
        if (cmd.mul)
        begin
            divd_reg <= {prod, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            divd_reg <= divd_reg << 1;
            rem_reg  <= rem_ge ? REF_W'(rem_diff) : REF_W'(rem_shift);
            q_reg    <= {q_reg[Q_W-2:0], rem_ge};
            ovf_reg  <= ovf_reg | q_reg[Q_W-1];
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            if (zero_reg)
            begin
                word_reg    <= '0;
                m_reg       <= '0;
                n_out_reg   <= '0;
                od_out_reg  <= '0;
                frac_reg    <= '0;
                sat_out_reg <= 1'b0;
                bad_reg     <= 1'b1;
            end
            else
            begin
                word_reg    <= word_val;
                m_reg       <= m_val;
                n_out_reg   <= n_reg;
                od_out_reg  <= od_reg;
                frac_reg    <= frac18;
                sat_out_reg <= sat_reg | m_ovf;
                bad_reg     <= 1'b0;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign pll_word    = word_reg;
    assign mult_int    = m_reg;
    assign prediv      = n_out_reg;
    assign postdiv_log = od_out_reg;
    assign mult_frac   = frac_reg;
    assign saturated   = sat_out_reg;
    assign bad_input   = bad_reg;

endmodule

FILE: hdl/pll_divider_search_top.sv
// The search steps the pre-divider, low and high compares in turn, then the post-divider
// the same way, either search stopping early at a bound; then a multiply step, the
// restoring division and the load of the result register. A zero clock input goes
// straight from the first compare to the result register.
// Each item runs to completion before the next is taken; the next item is taken while a
// result waits, and its own result waits until that one is read. rst_n clears the
// sequencer and the result valid flag; no other register is reset.
module pll_divider_search_top
    import pds_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [REF_W-1:0]      ref_clock_khz,
    input  logic [PIX_W-1:0]      pixel_clock_khz,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [WORD_W-1:0]     pll_word,
    output logic [M_W-1:0]        mult_int,
    output logic [N_W-1:0]        prediv,
    output logic [OD_W-1:0]       postdiv_log,
    output logic [FRAC_OUT_W-1:0] mult_frac,
    output logic                  saturated,
    output logic                  bad_input
);

    pds_cmd_t    cmd;
    pds_status_t status;

    pds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pds_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .ref_clock_khz   (ref_clock_khz),
        .pixel_clock_khz (pixel_clock_khz),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .pll_word        (pll_word),
        .mult_int        (mult_int),
        .prediv          (prediv),
        .postdiv_log     (postdiv_log),
        .mult_frac       (mult_frac),
        .saturated       (saturated),
        .bad_input       (bad_input)
    );

endmodule

FILE: hdl/pds_checker.sv
// Port-level checks for pll_divider_search_top, attached by the bind below.
// Depends on pds_pkg for field widths.
module pds_props
    import pds_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [WORD_W-1:0]     pll_word,
    input logic [M_W-1:0]        mult_int,
    input logic [N_W-1:0]        prediv,
    input logic [OD_W-1:0]       postdiv_log,
    input logic [FRAC_OUT_W-1:0] mult_frac,
    input logic                  saturated,
    input logic                  bad_input
);

    // A stalled result holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(pll_word) && $stable(bad_input))
        else $error("result changed while stalled");

    // A zero clock gives an all-zero result apart from the error flag.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bad_input |-> pll_word == '0 && mult_int == '0 && prediv == '0
            && postdiv_log == '0 && mult_frac == '0 && !saturated)
        else $error("bad input result not cleared");

    // The multiplier sits alone in the low byte of the word, and N never reaches zero.
    a_word_low: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !bad_input |-> pll_word[7:0] == mult_int && prediv != '0)
        else $error("packed word disagrees with its fields");

    // Once an item is taken the block is busy for at least the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken back to back");

endmodule

bind pll_divider_search_top pds_props u_pds_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .pll_word    (pll_word),
    .mult_int    (mult_int),
    .prediv      (prediv),
    .postdiv_log (postdiv_log),
    .mult_frac   (mult_frac),
    .saturated   (saturated),
    .bad_input   (bad_input)
);

FILE: verif/pds_checker.sv
// Checker for the PLL divider search block: watches both channels, predicts each result
// from the accepted clock pair and compares it field by field in order of arrival.
// Depends on pds_pkg for widths, bounds and search constants.
module pds_checker
    import pds_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  logic [REF_W-1:0]      ref_clock_khz,
    input  logic [PIX_W-1:0]      pixel_clock_khz,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  logic [WORD_W-1:0]     pll_word,
    input  logic [M_W-1:0]        mult_int,
    input  logic [N_W-1:0]        prediv,
    input  logic [OD_W-1:0]       postdiv_log,
    input  logic [FRAC_OUT_W-1:0] mult_frac,
    input  logic                  saturated,
    input  logic                  bad_input,
    output int                    mismatches,
    output int                    awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEARCH_CAP = 600;

    typedef struct packed {
        logic [WORD_W-1:0]     word;
        logic [M_W-1:0]        mult;
        logic [N_W-1:0]        n;
        logic [OD_W-1:0]       od;
        logic [FRAC_OUT_W-1:0] frac;
        logic                  sat;
        logic                  bad;
    } pll_setting_t;

    pll_setting_t expected_settings[$];
    int           results_seen   = 0;
    int           mismatch_count = 0;
    int           pending_count  = 0;

    assign mismatches = mismatch_count;
    assign awaiting   = pending_count;

    function automatic pll_setting_t compute_pll_setting(input logic [REF_W-1:0] ref_khz,
                                                         input logic [PIX_W-1:0] pix_khz);
        pll_setting_t s;
        logic [63:0]  r;
        logic [63:0]  p;
        logic [63:0]  prod;
        logic [63:0]  m;
        logic [63:0]  frac;
        logic [63:0]  word;
        logic [N_W-1:0]  n;
        logic [OD_W-1:0] od;
        logic         moved;
        logic         stuck;
        logic         sat;
        int           steps;
        s = '0;
        if (ref_khz == '0 || pix_khz == '0)
        begin
            s.bad = 1'b1;
            return s;
        end
        r   = 64'(ref_khz);
        p   = 64'(pix_khz);
        n   = N_START;
        od  = OD_START;
        sat = 1'b0;

        // Pre-divider: pull ref/N up to the low bound first, then down under the high one.
        moved = 1'b1;
        stuck = 1'b0;
        for (steps = 0; moved && !stuck && steps < SEARCH_CAP; steps++)
        begin
            moved = 1'b0;
            if (r / n < VCO_IN_LOW)
            begin
                if (n <= N_MIN)
                    stuck = 1'b1;
                else
                begin
                    n--;
                    moved = 1'b1;
                end
            end
            if (!stuck && r / n > VCO_IN_HIGH)
            begin
                if (n >= N_MAX)
                    stuck = 1'b1;
                else
                begin
                    n++;
                    moved = 1'b1;
                end
            end
        end
        sat = sat | stuck;

        moved = 1'b1;
        stuck = 1'b0;
        for (steps = 0; moved && !stuck && steps < SEARCH_CAP; steps++)
        begin
            moved = 1'b0;
            if ((p << od) < VCO_OUT_LOW)
            begin
                if (od >= OD_MAX)
                    stuck = 1'b1;
                else
                begin
                    od++;
                    moved = 1'b1;
                end
            end
            if (!stuck && (p << od) > VCO_OUT_HIGH)
            begin
                if (od == OD_MIN)
                    stuck = 1'b1;
                else
                begin
                    od--;
                    moved = 1'b1;
                end
            end
        end
        sat = sat | stuck;

        prod = (p * 64'(n)) << od;
        m    = prod / r;
        frac = ((prod << FRAC_BITS) / r) & ((64'd1 << FRAC_BITS) - 64'd1);
        if (m > 64'(M_MAX))
        begin
            m   = 64'(M_MAX);
            sat = 1'b1;
        end
        // The fields overlap in the packed word, so they are added, not ORed.
        word = (frac << WORD_FRAC_POS) + (64'(od) << WORD_OD_POS)
             + (64'(n) << WORD_N_POS) + m;

        s.word = word[WORD_W-1:0];
        s.mult = m[M_W-1:0];
        s.n    = n;
        s.od   = od;
        s.frac = frac[FRAC_OUT_W-1:0];
        s.sat  = sat;
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge clk)
    begin
        pll_setting_t want;
        if (rst_n)
        begin
            // A result accepted together with a new item belongs to an older item.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_settings.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no item pending",
                                              results_seen));
                else
                begin
                    want = expected_settings.pop_front();
                    check_field("pll_word", pll_word, want.word);
                    check_field("mult_int", WORD_W'(mult_int), WORD_W'(want.mult));
                    check_field("prediv", WORD_W'(prediv), WORD_W'(want.n));
                    check_field("postdiv_log", WORD_W'(postdiv_log), WORD_W'(want.od));
                    check_field("mult_frac", WORD_W'(mult_frac), WORD_W'(want.frac));
                    check_field("saturated", WORD_W'(saturated), WORD_W'(want.sat));
                    check_field("bad_input", WORD_W'(bad_input), WORD_W'(want.bad));
                end
                results_seen++;
            end
            if (req_valid && req_ready)
                expected_settings.push_back(compute_pll_setting(ref_clock_khz,
                                                                pixel_clock_khz));
        end
        pending_count <= expected_settings.size();
    end

endmodule

FILE: verif/tb.sv
// Testbench top for pll_divider_search_top: clock, reset, clock-pair stimulus and verdict.
// Depends on pds_pkg, the block itself and pds_checker, which predicts and checks each result.
module tb;
    import pds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 200;

    logic                  clk;
    logic                  rst_n           = 1'b0;
    logic                  req_valid       = 1'b0;
    logic                  req_ready;
    logic [REF_W-1:0]      ref_clock_khz   = '0;
    logic [PIX_W-1:0]      pixel_clock_khz = '0;
    logic                  rsp_valid;
    logic                  rsp_ready       = 1'b0;
    logic [WORD_W-1:0]     pll_word;
    logic [M_W-1:0]        mult_int;
    logic [N_W-1:0]        prediv;
    logic [OD_W-1:0]       postdiv_log;
    logic [FRAC_OUT_W-1:0] mult_frac;
    logic                  saturated;
    logic                  bad_input;

    int          mismatches;
    int          awaiting;
    bit          idling      = 1'b1;
    int unsigned cycle_count = 0;

    pll_divider_search_top #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .ref_clock_khz(ref_clock_khz),
        .pixel_clock_khz(pixel_clock_khz),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .pll_word(pll_word),
        .mult_int(mult_int),
        .prediv(prediv),
        .postdiv_log(postdiv_log),
        .mult_frac(mult_frac),
        .saturated(saturated),
        .bad_input(bad_input)
    );

    pds_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .ref_clock_khz(ref_clock_khz),
        .pixel_clock_khz(pixel_clock_khz),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .pll_word(pll_word),
        .mult_int(mult_int),
        .prediv(prediv),
        .postdiv_log(postdiv_log),
        .mult_frac(mult_frac),
        .saturated(saturated),
        .bad_input(bad_input),
        .mismatches(mismatches),
        .awaiting(awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, now and then a long one, none in the quiet stretch.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idling && $urandom_range(0, 99) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
                rsp_ready <= idling ? ($urandom_range(0, 99) >= 25) : 1'b1;
        end
    end

    // Called at a clock edge; returns at the edge where the item is accepted.
    task automatic send_clocks(input logic [REF_W-1:0] ref_khz,
                               input logic [PIX_W-1:0] pix_khz);
        if (idling && $urandom_range(0, 99) < 32)
        begin
            req_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 120)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid       <= 1'b1;
        ref_clock_khz   <= ref_khz;
        pixel_clock_khz <= pix_khz;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_all_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    task automatic pick_clocks(output logic [REF_W-1:0] ref_khz,
                               output logic [PIX_W-1:0] pix_khz);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            // Realistic crystal and pixel clock pairs.
            ref_khz = REF_W'($urandom_range(5000, 200000));
            pix_khz = PIX_W'($urandom_range(1000, 700000));
        end
        else if (sel < 67)
        begin
            ref_khz = REF_W'($urandom);
            pix_khz = PIX_W'($urandom);
        end
        else if (sel < 75)
        begin
            ref_khz = REF_W'($urandom_range(0, 8));
            pix_khz = PIX_W'($urandom_range(0, 8));
        end
        else if (sel < 83)
        begin
            // Slow reference against a fast pixel clock often pushes M past its limit.
            ref_khz = REF_W'($urandom_range(1, 6000));
            pix_khz = PIX_W'($urandom_range(100000, 1048575));
        end
        else if (sel < 92)
        begin
            ref_khz = REF_W'(5000 * $urandom_range(1, 60) + $urandom_range(0, 2) - 1);
            if ($urandom_range(0, 1) == 0)
                pix_khz = PIX_W'((700000 >> $urandom_range(0, 7)) + $urandom_range(0, 2) - 1);
            else
                pix_khz = PIX_W'((200000 >> $urandom_range(0, 7)) + $urandom_range(0, 2) - 1);
        end
        else
        begin
            ref_khz = REF_W'(32'd1 << $urandom_range(0, REF_W - 1));
            pix_khz = PIX_W'(32'd1 << $urandom_range(0, PIX_W - 1));
            if ($urandom_range(0, 1) == 0)
                ref_khz = ~ref_khz;
            if ($urandom_range(0, 1) == 0)
                pix_khz = ~pix_khz;
        end
    endtask

    initial
    begin
        logic [REF_W-1:0] ref_khz;
        logic [PIX_W-1:0] pix_khz;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero clocks, bounds of both searches and multiplier overflow.
        send_clocks('0, '0);
        send_clocks('0, PIX_W'(25175));
        send_clocks(REF_W'(14318), '0);
        send_clocks(REF_W'(1), PIX_W'(1));
        send_clocks('1, '1);
        send_clocks(REF_W'(1), '1);
        send_clocks('1, PIX_W'(1));
        send_clocks(REF_W'(14318), PIX_W'(25175));
        send_clocks(REF_W'(33333), PIX_W'(65000));
        send_clocks(REF_W'(4999), PIX_W'(108000));
        send_clocks(REF_W'(5000), PIX_W'(148500));
        send_clocks(REF_W'(200000), PIX_W'(200000));
        send_clocks(REF_W'(200001), PIX_W'(700000));
        send_clocks(REF_W'(250000), PIX_W'(700001));
        send_clocks(REF_W'(100000), PIX_W'(1562));
        send_clocks(REF_W'(100000), PIX_W'(1563));
        send_clocks(REF_W'(27000), PIX_W'(350000));
        send_clocks(REF_W'(48000), PIX_W'(50000));
        send_clocks(REF_W'(24000), PIX_W'(40000));
        send_clocks(REF_W'(20'h55555), PIX_W'(20'hAAAAA));
        send_clocks(REF_W'(20'hAAAAA), PIX_W'(20'h55555));
        wait_all_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idling = !(i >= 200 && i < 350);
            if (i == 400)
                wait_all_results();
            pick_clocks(ref_khz, pix_khz);
            send_clocks(ref_khz, pix_khz);
        end
        idling = 1'b1;

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaiting == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/pds_pkg.sv
hdl/pds_ctrl.sv
hdl/pds_datapath.sv
hdl/pll_divider_search_top.sv
hdl/pds_checker.sv
verif/pds_checker.sv
verif/tb.sv
